>>> rtl/kreg_pkg.sv
// Shared types and constants of the curve k-regularity measure block.
`default_nettype none

package kreg_pkg;

    // Field widths fixed by the pixel and result formats.
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;
    localparam int OUT_W      = FRAC_BITS + 1;
    localparam int CFG_W      = 6;
    localparam int CFG_IDX_W  = 1;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] SPACING_RESET = 6'd2;
    localparam logic [CFG_W-1:0] COUNT_RESET   = 6'd3;

    // Square root datapath: lengths are Q.8, root of (dx*dx + dy*dy) << 16.
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int ROOT_W = COORD_BITS + 9;
    localparam int RAD_W  = 2 * ROOT_W;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_SPACING = 1'b0,
        REG_STEP_COUNT   = 1'b1
    } cfg_reg_t;

    // One curve pixel.
    typedef struct packed {
        logic [COORD_BITS-1:0] x_coord;
        logic [COORD_BITS-1:0] y_coord;
        logic                  last_pixel;
    } in_item_t;

    // One curve result.
    typedef struct packed {
        logic [OUT_W-1:0] curve_mean;
        logic             curve_measured;
        logic             curve_overflow;
        logic [OUT_W-1:0] max_mean;
        logic [OUT_W-1:0] min_mean;
    } out_item_t;

    // Pixel as classified by the front end.
    typedef struct packed {
        in_item_t item;
        logic     drop;
    } front_req_t;

endpackage

`default_nettype wire

>>> rtl/kreg_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module kreg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/kreg_front.sv
// Front end: accepts pixels, tracks the curve length and queues them.
`default_nettype none

module kreg_front
    import kreg_pkg::*;
#(
    parameter int MAX_CURVE_LEN = 65536,
    parameter int CNT_W         = 17
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire in_item_t         in_data,
    output logic                  q_valid,
    output front_req_t            q_req,
    output logic      [CNT_W-1:0] q_cnt,
    input  wire logic             q_pop
);

    logic [CNT_W-1:0] n_reg;
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       fill_reg;
    front_req_t       req_reg [2];
    logic [CNT_W-1:0] cnt_reg [2];
    logic             push;
    logic             drop;

    assign in_ready = (fill_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign drop     = (n_reg >= CNT_W'(MAX_CURVE_LEN));
    assign q_valid  = (fill_reg != 2'd0);
    assign q_req    = req_reg[rd_ptr_reg];
    assign q_cnt    = cnt_reg[rd_ptr_reg];

    // Pixel count of the current curve; pixels past the limit are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg      <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                if (in_data.last_pixel)
                begin
                    n_reg <= '0;
                end
                else if (!drop)
                begin
                    n_reg <= n_reg + 1'b1;
                end
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !q_pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (!push && q_pop)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    // Two-entry request queue payload.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            req_reg[wr_ptr_reg] <= '{item: in_data, drop: drop};
            cnt_reg[wr_ptr_reg] <= n_reg;
        end
    end

endmodule

`default_nettype wire

>>> rtl/kreg_sqrt.sv
// Bit-serial integer square root, one root bit per cycle.
`default_nettype none

module kreg_sqrt
    import kreg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [RAD_W-1:0]  operand,
    output logic                   done,
    output logic      [ROOT_W-1:0] root
);

    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  op_reg;
    logic [ROOT_W+1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [ROOT_W+3:0] rem2;
    logic [ROOT_W+3:0] trial;
    logic              fits;

    assign rem2  = {rem_reg, op_reg[RAD_W-1 -: 2]};
    assign trial = (ROOT_W + 4)'({root_reg, 2'b01});
    assign fits  = (rem2 >= trial);
    assign done  = done_reg;
    assign root  = root_reg;

    // Restoring square root over the operand, two bits per step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W);
                op_reg   <= operand;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            else if (busy_reg)
            begin
                op_reg <= op_reg << 2;
                if (fits)
                begin
                    rem_reg  <= (ROOT_W + 2)'(rem2 - trial);
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= (ROOT_W + 2)'(rem2);
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/kreg_div.sv
// Restoring divider, one quotient bit per cycle, shared by ratio and mean.
`default_nettype none

module kreg_div
    import kreg_pkg::*;
#(
    parameter int NUM_W = 34,
    parameter int DEN_W = 27
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [DEN_W-1:0]             rem_init,
    input  wire logic [DEN_W-1:0]             den,
    input  wire logic [NUM_W-1:0]             num,
    input  wire logic [$clog2(NUM_W+1)-1:0]   steps,
    output logic                              done,
    output logic      [OUT_W-1:0]             quot
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [OUT_W-1:0]  quot_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DEN_W:0]    rem2;
    logic [DEN_W:0]    diff;
    logic              fits;

    assign rem2 = {rem_reg, num_reg[NUM_W-1]};
    assign diff = rem2 - {1'b0, den_reg};
    assign fits = (rem2 >= {1'b0, den_reg});
    assign done = done_reg;
    assign quot = quot_reg;

    // Shift in one dividend bit a cycle; the remainder always stays below den.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            num_reg  <= '0;
            quot_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
                rem_reg  <= rem_init;
                den_reg  <= den;
                num_reg  <= num;
                quot_reg <= '0;
            end
            else if (busy_reg)
            begin
                num_reg  <= num_reg << 1;
                rem_reg  <= fits ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
                quot_reg <= {quot_reg[OUT_W-2:0], fits};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/kreg_back.sv
// Back end: history rings, step and chord lengths, ratios and curve results.
`default_nettype none

module kreg_back
    import kreg_pkg::*;
#(
    parameter int MAX_SPAN = 63,
    parameter int CNT_W    = 17
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [CFG_W-1:0] step_spacing,
    input  wire logic [CFG_W-1:0] step_count,
    input  wire logic             q_valid,
    input  wire front_req_t       q_req,
    input  wire logic [CNT_W-1:0] q_cnt,
    output logic                  q_pop,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output out_item_t             out_data
);

    localparam int DEPTH  = MAX_SPAN + 1;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int SPAN_W = 2 * CFG_W;
    localparam int BS_W   = ((PTR_W > SPAN_W) ? PTR_W : SPAN_W) + 2;
    localparam int CMP_W  = ((CNT_W > SPAN_W) ? CNT_W : SPAN_W) + 1;
    localparam int ARC_W  = ROOT_W + PTR_W;
    localparam int SUM_W  = CNT_W + FRAC_BITS;
    localparam int NUM_W  = SUM_W + 1;
    localparam int DEN_W  = (ARC_W > CNT_W) ? ARC_W : CNT_W;
    localparam int STEP_W = $clog2(NUM_W + 1);
    localparam logic [SUM_W-1:0] ONE_Q = SUM_W'(1) << FRAC_BITS;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEN_RD,
        ST_LEN_SQ,
        ST_LEN_RT,
        ST_STEP_WR,
        ST_ARC_RD,
        ST_ARC_ACC,
        ST_RATIO,
        ST_RATIO_WAIT,
        ST_END,
        ST_MEAN_WAIT,
        ST_OUT
    } state_t;

    state_t                state_reg;
    logic [COORD_BITS-1:0] x_reg;
    logic [COORD_BITS-1:0] y_reg;
    logic                  last_reg;
    logic                  drop_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  chord_sel_reg;
    logic [PTR_W-1:0]      pos_reg;
    logic [SQ_W-1:0]       sq_x_reg;
    logic [SQ_W-1:0]       sq_y_reg;
    logic [ROOT_W-1:0]     step_reg;
    logic [ROOT_W-1:0]     chord_reg;
    logic [ARC_W-1:0]      arc_reg;
    logic [SPAN_W-1:0]     off_reg;
    logic [CFG_W-1:0]      j_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic                  over_reg;
    logic                  measured_reg;
    logic [OUT_W-1:0]      mean_reg;
    logic [OUT_W-1:0]      best_reg;
    logic [OUT_W-1:0]      least_reg;
    logic                  out_valid_reg;
    out_item_t             out_data_reg;

    logic                  hist_we;
    logic [PTR_W-1:0]      hist_raddr;
    logic [SQ_W-1:0]       hist_wdata;
    logic [SQ_W-1:0]       hist_rdata;
    logic                  sl_we;
    logic [PTR_W-1:0]      sl_raddr;
    logic [ROOT_W-1:0]     sl_rdata;
    logic                  sqrt_start;
    logic                  sqrt_done;
    logic [ROOT_W-1:0]     sqrt_root;
    logic [RAD_W-1:0]      sqrt_operand;
    logic                  div_start;
    logic                  div_done;
    logic [OUT_W-1:0]      div_quot;
    logic [DEN_W-1:0]      div_rem_init;
    logic [DEN_W-1:0]      div_den;
    logic [NUM_W-1:0]      div_num;
    logic [STEP_W-1:0]     div_steps;

    logic [SPAN_W-1:0]     s_ext;
    logic [SPAN_W-1:0]     span;
    logic                  span_ok;
    logic                  step_ok;
    logic                  win_ok;
    logic [CMP_W-1:0]      cnt_after;
    logic                  measured;
    logic [CNT_W-1:0]      windows;
    logic [COORD_BITS-1:0] old_x;
    logic [COORD_BITS-1:0] old_y;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [OUT_W-1:0]      best_new;
    logic [OUT_W-1:0]      least_new;
    logic                  slot_free;

    // Ring slot that lies a given distance behind a position.
    function automatic logic [PTR_W-1:0] back_slot(input logic [PTR_W-1:0] p,
                                                   input logic [SPAN_W-1:0] off);
        logic [BS_W-1:0] t;
        t = BS_W'(p) + BS_W'(DEPTH) - BS_W'(off);
        if (t >= BS_W'(DEPTH))
        begin
            t = t - BS_W'(DEPTH);
        end
        return t[PTR_W-1:0];
    endfunction

    // Span checks for the current spacing and count.
    assign s_ext   = SPAN_W'(step_spacing);
    assign span    = s_ext * SPAN_W'(step_count);
    assign span_ok = (step_spacing != '0) && (step_count != '0) &&
                     (span <= SPAN_W'(MAX_SPAN));
    assign step_ok = (step_spacing != '0) && (s_ext <= SPAN_W'(MAX_SPAN)) &&
                     (CMP_W'(q_cnt) >= CMP_W'(s_ext));
    assign win_ok  = span_ok && (CMP_W'(cnt_reg) >= CMP_W'(span));
    assign cnt_after = drop_reg ? CMP_W'(cnt_reg) : CMP_W'(cnt_reg) + CMP_W'(1);
    assign measured  = span_ok && (cnt_after > CMP_W'(span));
    assign windows   = CNT_W'(cnt_after - CMP_W'(span));

    // Absolute coordinate differences to the stored point.
    assign old_x = hist_rdata[SQ_W-1 -: COORD_BITS];
    assign old_y = hist_rdata[COORD_BITS-1:0];
    assign dx    = (x_reg > old_x) ? x_reg - old_x : old_x - x_reg;
    assign dy    = (y_reg > old_y) ? y_reg - old_y : old_y - y_reg;

    // Running extremes including the curve being finished.
    assign best_new  = (measured_reg && mean_reg > best_reg) ? mean_reg : best_reg;
    assign least_new = (measured_reg && mean_reg < least_reg) ? mean_reg : least_reg;
    assign slot_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Memory, square root and divider controls for each state.
    always_comb
    begin
        q_pop        = 1'b0;
        hist_we      = 1'b0;
        hist_wdata   = {q_req.item.x_coord, q_req.item.y_coord};
        hist_raddr   = back_slot(pos_reg, s_ext);
        sl_we        = 1'b0;
        sl_raddr     = back_slot(pos_reg, off_reg);
        sqrt_start   = 1'b0;
        sqrt_operand = {RAD_W'(sq_x_reg) + RAD_W'(sq_y_reg)} << 16;
        div_start    = 1'b0;
        div_rem_init = DEN_W'(chord_reg);
        div_den      = DEN_W'(arc_reg);
        div_num      = '0;
        div_steps    = STEP_W'(FRAC_BITS);
        unique case (state_reg)
            ST_IDLE:
            begin
                q_pop   = q_valid;
                hist_we = q_valid && !q_req.drop;
            end
            ST_LEN_SQ:
            begin
                sqrt_start = 1'b1;
            end
            ST_STEP_WR:
            begin
                sl_we      = 1'b1;
                hist_raddr = back_slot(pos_reg, span);
            end
            ST_RATIO:
            begin
                div_start = (arc_reg != '0) && (ARC_W'(chord_reg) < arc_reg);
            end
            ST_END:
            begin
                div_start    = last_reg && measured;
                div_rem_init = '0;
                div_den      = DEN_W'(windows);
                div_num      = NUM_W'(sum_reg) + NUM_W'(windows >> 1);
                div_steps    = STEP_W'(NUM_W);
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer for one pixel at a time.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            sum_reg       <= '0;
            over_reg      <= 1'b0;
            best_reg      <= '0;
            least_reg     <= '1;
            out_valid_reg <= 1'b0;
            x_reg         <= '0;
            y_reg         <= '0;
            last_reg      <= 1'b0;
            drop_reg      <= 1'b0;
            cnt_reg       <= '0;
            chord_sel_reg <= 1'b0;
            sq_x_reg      <= '0;
            sq_y_reg      <= '0;
            step_reg      <= '0;
            chord_reg     <= '0;
            arc_reg       <= '0;
            off_reg       <= '0;
            j_reg         <= '0;
            measured_reg  <= 1'b0;
            mean_reg      <= '0;
            out_data_reg  <= '0;
        end
        else
        begin
            // A result taken while a new one is loaded is replaced in ST_OUT.
            if (out_valid_reg && out_ready && (state_reg != ST_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        x_reg    <= q_req.item.x_coord;
                        y_reg    <= q_req.item.y_coord;
                        last_reg <= q_req.item.last_pixel;
                        drop_reg <= q_req.drop;
                        cnt_reg  <= q_cnt;
                        if (q_req.drop)
                        begin
                            over_reg  <= 1'b1;
                            state_reg <= ST_END;
                        end
                        else if (step_ok)
                        begin
                            chord_sel_reg <= 1'b0;
                            state_reg     <= ST_LEN_RD;
                        end
                        else
                        begin
                            step_reg  <= '0;
                            state_reg <= ST_STEP_WR;
                        end
                    end
                end
                ST_LEN_RD:
                begin
                    sq_x_reg  <= SQ_W'(dx) * SQ_W'(dx);
                    sq_y_reg  <= SQ_W'(dy) * SQ_W'(dy);
                    state_reg <= ST_LEN_SQ;
                end
                ST_LEN_SQ:
                begin
                    state_reg <= ST_LEN_RT;
                end
                ST_LEN_RT:
                begin
                    if (sqrt_done)
                    begin
                        if (!chord_sel_reg)
                        begin
                            step_reg  <= sqrt_root;
                            state_reg <= ST_STEP_WR;
                        end
                        else
                        begin
                            chord_reg <= sqrt_root;
                            arc_reg   <= ARC_W'(step_reg);
                            off_reg   <= s_ext;
                            j_reg     <= CFG_W'(1);
                            state_reg <= (step_count == CFG_W'(1)) ? ST_RATIO : ST_ARC_RD;
                        end
                    end
                end
                ST_STEP_WR:
                begin
                    if (win_ok)
                    begin
                        chord_sel_reg <= 1'b1;
                        state_reg     <= ST_LEN_RD;
                    end
                    else
                    begin
                        state_reg <= ST_END;
                    end
                end
                ST_ARC_RD:
                begin
                    state_reg <= ST_ARC_ACC;
                end
                ST_ARC_ACC:
                begin
                    arc_reg <= arc_reg + ARC_W'(sl_rdata);
                    if (j_reg + CFG_W'(1) == step_count)
                    begin
                        state_reg <= ST_RATIO;
                    end
                    else
                    begin
                        j_reg     <= j_reg + CFG_W'(1);
                        off_reg   <= off_reg + s_ext;
                        state_reg <= ST_ARC_RD;
                    end
                end
                ST_RATIO:
                begin
                    if ((arc_reg == '0) || (ARC_W'(chord_reg) >= arc_reg))
                    begin
                        sum_reg   <= sum_reg + ONE_Q;
                        state_reg <= ST_END;
                    end
                    else
                    begin
                        state_reg <= ST_RATIO_WAIT;
                    end
                end
                ST_RATIO_WAIT:
                begin
                    if (div_done)
                    begin
                        sum_reg   <= sum_reg + SUM_W'(div_quot);
                        state_reg <= ST_END;
                    end
                end
                ST_END:
                begin
                    if (!drop_reg)
                    begin
                        pos_reg <= (pos_reg == PTR_W'(DEPTH - 1)) ? '0 : pos_reg + 1'b1;
                    end
                    measured_reg <= measured;
                    mean_reg     <= '0;
                    if (!last_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (measured)
                    begin
                        state_reg <= ST_MEAN_WAIT;
                    end
                    else
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_MEAN_WAIT:
                begin
                    if (div_done)
                    begin
                        mean_reg  <= div_quot;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg                <= 1'b1;
                        out_data_reg.curve_mean      <= mean_reg;
                        out_data_reg.curve_measured  <= measured_reg;
                        out_data_reg.curve_overflow  <= over_reg;
                        out_data_reg.max_mean        <= best_new;
                        out_data_reg.min_mean        <= least_new;
                        best_reg                     <= best_new;
                        least_reg                    <= least_new;
                        sum_reg                      <= '0;
                        pos_reg                      <= '0;
                        over_reg                     <= 1'b0;
                        state_reg                    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Ring of recent pixel coordinates.
    kreg_ram #(
        .WIDTH (SQ_W),
        .DEPTH (DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (pos_reg),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    // Ring of step lengths at the current spacing.
    kreg_ram #(
        .WIDTH (ROOT_W),
        .DEPTH (DEPTH)
    ) u_step_ram (
        .clk   (clk),
        .we    (sl_we),
        .waddr (pos_reg),
        .wdata (step_reg),
        .raddr (sl_raddr),
        .rdata (sl_rdata)
    );

    kreg_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sqrt_start),
        .operand (sqrt_operand),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    kreg_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (div_rem_init),
        .den      (div_den),
        .num      (div_num),
        .steps    (div_steps),
        .done     (div_done),
        .quot     (div_quot)
    );

endmodule

`default_nettype wire

>>> rtl/curve_k_regularity_measure_core.sv
// Top level of the curve k-regularity measure block.
//
//   Channel   Handshake                 Payload
//   in        in_valid / in_ready       in_data   (in_item_t, one pixel)
//   out       out_valid / out_ready     out_data  (out_item_t, one curve)
//   cfg       cfg_we                    cfg_index, cfg_data
//
// A pixel makes up to two passes through the bit-serial square root, one ring read
// per arc step and one pass through the bit-serial divider; the last pixel of a
// curve adds a divider pass for the mean. Reset clears all control state; the rings
// need no clearing.
// A two-entry queue takes requests while the back end works or a result waits.
`default_nettype none

module curve_k_regularity_measure_core
    import kreg_pkg::*;
#(
    parameter int MAX_SPAN      = 63,
    parameter int MAX_CURVE_LEN = 65536
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire in_item_t             in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output out_item_t                 out_data,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int CNT_W = $clog2(MAX_CURVE_LEN + 1);

    logic [CFG_W-1:0] spacing_reg;
    logic [CFG_W-1:0] count_reg;
    logic             q_valid;
    front_req_t       q_req;
    logic [CNT_W-1:0] q_cnt;
    logic             q_pop;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg <= SPACING_RESET;
            count_reg   <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_STEP_SPACING: spacing_reg <= cfg_data;
                REG_STEP_COUNT:   count_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    kreg_front #(
        .MAX_CURVE_LEN (MAX_CURVE_LEN),
        .CNT_W         (CNT_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_req    (q_req),
        .q_cnt    (q_cnt),
        .q_pop    (q_pop)
    );

    kreg_back #(
        .MAX_SPAN (MAX_SPAN),
        .CNT_W    (CNT_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_spacing (spacing_reg),
        .step_count   (count_reg),
        .q_valid      (q_valid),
        .q_req        (q_req),
        .q_cnt        (q_cnt),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

endmodule

`default_nettype wire

>>> bench/tb.sv
// Self-checking testbench for the curve k-regularity measure core.
`timescale 1ns / 1ps
`default_nettype none

module tb;
    import kreg_pkg::*;

    localparam int SPAN_LIMIT = 63;
    localparam int CURVE_LIMIT = 65536;
    localparam int RING = SPAN_LIMIT + 1;
    localparam int ONE_Q = 1 << FRAC_BITS;
    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    curve_k_regularity_measure_core u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Predictor state.
    logic [5:0] spacing_q, count_q;
    logic [COORD_BITS-1:0] ring_x [RING];
    logic [COORD_BITS-1:0] ring_y [RING];
    logic [ROOT_W-1:0] ring_len [RING];
    logic [32:0] ratio_acc;
    int unsigned pix_n, ring_at;
    bit over_flag;
    logic [OUT_W-1:0] best_q, least_q;

    in_item_t pixel_queue[$];
    out_item_t curve_expect[$];
    int errors = 0;
    int send_idle_pct = 0, recv_stall_pct = 0;
    bit send_done = 0;
    int quiet_cycles = 0;

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic int unsigned slot_back(int unsigned back);
        return (ring_at + RING - (back % RING)) % RING;
    endfunction

    function automatic longint unsigned dist_q8(int unsigned a, int unsigned b);
        longint unsigned dx, dy;
        dx = ring_x[a] > ring_x[b] ? ring_x[a] - ring_x[b] : ring_x[b] - ring_x[a];
        dy = ring_y[a] > ring_y[b] ? ring_y[a] - ring_y[b] : ring_y[b] - ring_y[a];
        return root_floor((dx * dx + dy * dy) << 16);
    endfunction

    function automatic bit span_valid();
        return spacing_q != 0 && count_q != 0 && spacing_q * count_q <= SPAN_LIMIT;
    endfunction

    function automatic void clear_curve();
        ratio_acc = '0;
        pix_n = 0;
        ring_at = 0;
        over_flag = 0;
    endfunction

    // Advances the regularity model by one pixel and queues any curve result.
    function automatic void predict_pixel(in_item_t p);
        int unsigned s, n, span;
        longint unsigned chord, arc, ratio, windows;
        out_item_t r;
        s = spacing_q;
        n = pix_n;
        if (pix_n >= CURVE_LIMIT) begin
            over_flag = 1;
        end else begin
            ring_x[ring_at] = p.x_coord;
            ring_y[ring_at] = p.y_coord;
            if (s != 0 && n >= s)
                ring_len[ring_at] = ROOT_W'(dist_q8(ring_at, slot_back(s)));
            else
                ring_len[ring_at] = '0;
            if (span_valid() && n >= s * count_q) begin
                span = s * count_q;
                chord = dist_q8(ring_at, slot_back(span));
                arc = 0;
                for (int j = 0; j < count_q; j++)
                    arc += ring_len[slot_back(j * s)];
                if (arc == 0) begin
                    ratio = ONE_Q;
                end else begin
                    ratio = (chord << FRAC_BITS) / arc;
                    if (ratio > ONE_Q) ratio = ONE_Q;
                end
                ratio_acc = 33'(ratio_acc + ratio);
            end
            pix_n = n + 1;
            ring_at = (ring_at + 1) % RING;
        end
        if (!p.last_pixel) return;
        r = '0;
        if (span_valid() && pix_n > spacing_q * count_q) begin
            windows = pix_n - spacing_q * count_q;
            r.curve_mean = OUT_W'((ratio_acc + windows / 2) / windows);
            r.curve_measured = 1'b1;
            if (r.curve_mean > best_q) best_q = r.curve_mean;
            if (r.curve_mean < least_q) least_q = r.curve_mean;
        end
        r.curve_overflow = over_flag;
        r.max_mean = best_q;
        r.min_mean = least_q;
        curve_expect.push_back(r);
        clear_curve();
    endfunction

    // Request driver.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                predict_pixel(in_data);
            end
            if (!in_valid || in_ready) begin
                if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_data <= pixel_queue.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result monitor and watchdog.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (out_valid && out_ready) begin
                if (curve_expect.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, out_data);
                    errors++;
                end else begin
                    out_item_t e;
                    e = curve_expect.pop_front();
                    if (e.curve_mean !== out_data.curve_mean ||
                        e.curve_measured !== out_data.curve_measured ||
                        e.curve_overflow !== out_data.curve_overflow ||
                        e.max_mean !== out_data.max_mean ||
                        e.min_mean !== out_data.min_mean) begin
                        $display("%0t: mismatch expected %p actual %p", $time, e, out_data);
                        errors++;
                    end
                end
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic add_pixel(int x, int y, bit last);
        in_item_t p;
        p.x_coord = COORD_BITS'(x);
        p.y_coord = COORD_BITS'(y);
        p.last_pixel = last;
        pixel_queue.push_back(p);
    endtask

    // A curve of random shape: a walk, a line or scattered points.
    task automatic add_curve(int len);
        int x, y, shape;
        x = $urandom_range(4095);
        y = $urandom_range(4095);
        shape = $urandom_range(3);
        for (int i = 0; i < len; i++) begin
            if (shape == 0) begin
                x = $urandom_range(4095);
                y = $urandom_range(4095);
            end else if (shape == 1) begin
                x = (x + 3) & 4095;
                y = (y + 1) & 4095;
            end else begin
                x = (x + $urandom_range(2) - 1) & 4095;
                y = (y + $urandom_range(2) - 1) & 4095;
            end
            add_pixel(x, y, i == len - 1);
        end
    endtask

    task automatic drain();
        while (pixel_queue.size() > 0 || in_valid || curve_expect.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, int val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(val);
        if (idx == REG_STEP_SPACING) spacing_q = CFG_W'(val);
        else count_q = CFG_W'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int sent;
        spacing_q = SPACING_RESET;
        count_q = COUNT_RESET;
        best_q = '0;
        least_q = '1;
        clear_curve();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extreme coordinates, zero arc, short and single-pixel curves.
        add_pixel(0, 0, 0);
        add_pixel(4095, 4095, 0);
        add_pixel(0, 4095, 0);
        add_pixel(4095, 0, 0);
        add_pixel(2730, 1365, 0);
        add_pixel(1365, 2730, 0);
        add_pixel(4095, 4095, 0);
        add_pixel(0, 0, 1);
        for (int i = 0; i < 8; i++) add_pixel(100, 100, i == 7);
        add_pixel(7, 7, 1);
        add_pixel(1, 2, 0);
        add_pixel(3, 4, 1);
        drain();

        // Random phases over several settings, extremes included.
        sent = 0;
        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0: begin write_reg(REG_STEP_SPACING, 1); write_reg(REG_STEP_COUNT, 1); end
                1: begin write_reg(REG_STEP_SPACING, 63); write_reg(REG_STEP_COUNT, 1); end
                2: begin write_reg(REG_STEP_SPACING, 1); write_reg(REG_STEP_COUNT, 63); end
                3: begin write_reg(REG_STEP_SPACING, 63); write_reg(REG_STEP_COUNT, 63); end
                4: begin write_reg(REG_STEP_SPACING, 0); write_reg(REG_STEP_COUNT, 4); end
                5: begin write_reg(REG_STEP_SPACING, 2); write_reg(REG_STEP_COUNT, 0); end
                default: begin
                    write_reg(REG_STEP_SPACING, $urandom_range(1, 8));
                    write_reg(REG_STEP_COUNT, $urandom_range(1, 7));
                end
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 68; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 68; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            for (int c = 0; c < 8; c++) begin
                int len;
                len = (ph == 3) ? $urandom_range(1, 80) : $urandom_range(1, 20);
                add_curve(len);
                sent += len;
            end
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (sent < 1450) begin
            int len;
            len = $urandom_range(1, 20);
            add_curve(len);
            sent += len;
        end
        drain();

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

`default_nettype wire

>>> filelist.f
rtl/kreg_pkg.sv
rtl/kreg_ram.sv
rtl/kreg_front.sv
rtl/kreg_sqrt.sv
rtl/kreg_div.sv
rtl/kreg_back.sv
rtl/curve_k_regularity_measure_core.sv
bench/tb.sv
